### sv/bcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types, constants and helpers of the basecall byte decoder.
// ----------------------------------------------------------------------------
package bcd_pkg;

   localparam int BYTE_W    = 8;
   localparam int LETTER_W  = 7;
   localparam int QUAL_W    = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 8;
   localparam int NUM_BINS  = 4;
   localparam int NUM_LANES = 2;

   localparam logic [LETTER_W-1:0] LETTER_A = 7'h41;
   localparam logic [LETTER_W-1:0] LETTER_C = 7'h43;
   localparam logic [LETTER_W-1:0] LETTER_G = 7'h47;
   localparam logic [LETTER_W-1:0] LETTER_T = 7'h54;
   localparam logic [LETTER_W-1:0] LETTER_N = 7'h4E;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PACKED_MODE   = 3'd0,
      REG_FILTER_BYPASS = 3'd1,
      REG_BIN0_QUALITY  = 3'd2,
      REG_BIN1_QUALITY  = 3'd3,
      REG_BIN2_QUALITY  = 3'd4,
      REG_BIN3_QUALITY  = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic                packed_mode;
      logic                filter_bypass;
      logic [QUAL_W-1:0]   bin0_quality;
      logic [QUAL_W-1:0]   bin1_quality;
      logic [QUAL_W-1:0]   bin2_quality;
      logic [QUAL_W-1:0]   bin3_quality;
   } cfg_type;

   // One decoded cluster as a lane hands it to the merge stage.
   typedef struct packed {
      logic                keep;
      logic [LETTER_W-1:0] base_letter;
      logic [QUAL_W-1:0]   quality;
   } lane_res_type;

   // One result waiting in the merge stage.
   typedef struct packed {
      logic [LETTER_W-1:0] base_letter;
      logic [QUAL_W-1:0]   quality;
      logic                last_of_item;
   } slot_type;

   function automatic logic [LETTER_W-1:0] base_of_code(input logic [1:0] code);
      logic [LETTER_W-1:0] letter;
      case (code)
         2'd0:    letter = LETTER_A;
         2'd1:    letter = LETTER_C;
         2'd2:    letter = LETTER_G;
         2'd3:    letter = LETTER_T;
         default: letter = LETTER_N;
      endcase
      return letter;
   endfunction

endpackage

### sv/bcd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd channel interfaces
// Valid/ready channels for basecall bytes, decoded results and register writes.
// ----------------------------------------------------------------------------
interface bcd_req_if;
   import bcd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] call_byte;
   logic              pass_first;
   logic              pass_second;

   modport source (output valid, call_byte, pass_first, pass_second, input ready);
   modport sink   (input valid, call_byte, pass_first, pass_second, output ready);
endinterface

interface bcd_rsp_if;
   import bcd_pkg::*;
   logic                valid;
   logic                ready;
   logic [LETTER_W-1:0] base_letter;
   logic [QUAL_W-1:0]   quality;
   logic                last_of_item;

   modport source (output valid, base_letter, quality, last_of_item, input ready);
   modport sink   (input valid, base_letter, quality, last_of_item, output ready);
endinterface

interface bcd_csr_if;
   import bcd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### sv/basecall_byte_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// basecall_byte_decoder
// Turns basecall bytes into base letter and quality results.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one basecall byte and two pass-filter bits per item.
//   rsp_bus carries one base letter / quality pair per result, last_of_item
//   marking the final result of an input item; a packed item whose clusters
//   are both filtered out gives no result at all.
//   csr_bus writes the six configuration registers; it is always ready and
//   should only be used while the decoder is idle.
//   Two decode lanes work on the two nibbles of a byte in parallel and a
//   merge stage holds their results in two slots ahead of the output register.
//   The first result of an item is registered in a slot and then in the output
//   register before it is valid on rsp_bus.
//   Throughput is set by the single output register: one result per cycle
//   while the receiver does not stall, so one item per cycle in legacy mode;
//   a packed byte with two results admits the next item as its second moves out.
//   Reset clears the registers to legacy mode with filter bypass on and
//   empties the slots and the output register.
//   When the receiver stalls, the output holds its result and a new item is
//   accepted only once the slots have room for it.
// ----------------------------------------------------------------------------
module basecall_byte_decoder (
   input  logic       clock,
   input  logic       reset,
   bcd_req_if.sink    req_bus,
   bcd_rsp_if.source  rsp_bus,
   bcd_csr_if.sink    csr_bus
);
   import bcd_pkg::*;

   cfg_type      cfg;
   lane_res_type lanes [NUM_LANES];

   bcd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // The low-nibble lane also decodes the whole byte in legacy mode.
   bcd_lane u_lane_lo (
      .lane_en     (1'b1),
      .pass_bit    (req_bus.pass_first),
      .nibble      (req_bus.call_byte[3:0]),
      .legacy_qual (req_bus.call_byte[7:2]),
      .cfg         (cfg),
      .res         (lanes[0])
   );

   bcd_lane u_lane_hi (
      .lane_en     (cfg.packed_mode),
      .pass_bit    (req_bus.pass_second),
      .nibble      (req_bus.call_byte[7:4]),
      .legacy_qual (req_bus.call_byte[7:2]),
      .cfg         (cfg),
      .res         (lanes[1])
   );

   bcd_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .lanes     (lanes),
      .rsp_bus   (rsp_bus)
   );

endmodule

### sv/bcd_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_csr
// Configuration registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module bcd_csr (
   input  logic             clock,
   input  logic             reset,
   bcd_csr_if.sink          csr_bus,
   output bcd_pkg::cfg_type cfg
);
   import bcd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_bus.ready = 1'b1;
   assign wr_en         = csr_bus.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_idx_type'(csr_bus.index))
            REG_PACKED_MODE:   cfg_in.packed_mode   = csr_bus.data[0];
            REG_FILTER_BYPASS: cfg_in.filter_bypass = csr_bus.data[0];
            REG_BIN0_QUALITY:  cfg_in.bin0_quality  = csr_bus.data;
            REG_BIN1_QUALITY:  cfg_in.bin1_quality  = csr_bus.data;
            REG_BIN2_QUALITY:  cfg_in.bin2_quality  = csr_bus.data;
            REG_BIN3_QUALITY:  cfg_in.bin3_quality  = csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{packed_mode: 1'b0, filter_bypass: 1'b1, bin0_quality: '0,
                     bin1_quality: '0, bin2_quality: '0, bin3_quality: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/bcd_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_lane
// Decodes one cluster: base letter, quality and whether it is emitted.
// ----------------------------------------------------------------------------
module bcd_lane (
   input  logic                  lane_en,
   input  logic                  pass_bit,
   input  logic [3:0]            nibble,
   input  logic [5:0]            legacy_qual,
   input  bcd_pkg::cfg_type      cfg,
   output bcd_pkg::lane_res_type res
);
   import bcd_pkg::*;

   logic [QUAL_W-1:0] qual;
   logic [QUAL_W-1:0] bin_qual;

   always_comb begin
      case (nibble[3:2])
         2'd0:    bin_qual = cfg.bin0_quality;
         2'd1:    bin_qual = cfg.bin1_quality;
         2'd2:    bin_qual = cfg.bin2_quality;
         default: bin_qual = cfg.bin3_quality;
      endcase
   end

   assign qual = cfg.packed_mode ? bin_qual : {2'b00, legacy_qual};

   always_comb begin
      res.quality     = qual;
      res.base_letter = (qual == '0) ? LETTER_N : base_of_code(nibble[1:0]);
      // The pass-filter bits only count in packed mode.
      res.keep        = lane_en & (~cfg.packed_mode | cfg.filter_bypass | pass_bit);
   end

endmodule

### sv/bcd_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_merge
// Collects one item's lane results and sends them out one per cycle unless stalled.
// ----------------------------------------------------------------------------
module bcd_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bcd_pkg::lane_res_type lanes [bcd_pkg::NUM_LANES],
   bcd_rsp_if.source             rsp_bus
);
   import bcd_pkg::*;

   slot_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic     vld0_ff, vld0_in, vld1_ff, vld1_in;
   slot_type out_ff, out_in;
   logic     out_vld_ff, out_vld_in;
   logic     move;
   logic     accept;

   assign move      = ~out_vld_ff | rsp_bus.ready;
   // A new item may enter when the slots are empty or their last entry leaves now.
   assign req_ready = (~vld0_ff & ~vld1_ff) | (move & (vld0_ff ^ vld1_ff));
   assign accept    = req_valid & req_ready;

   always_comb begin
      slot0_in   = slot0_ff;
      slot1_in   = slot1_ff;
      vld0_in    = vld0_ff;
      vld1_in    = vld1_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff;
      if (move) begin
         if (vld0_ff) begin
            out_in     = slot0_ff;
            out_vld_in = 1'b1;
            vld0_in    = 1'b0;
         end else if (vld1_ff) begin
            out_in     = slot1_ff;
            out_vld_in = 1'b1;
            vld1_in    = 1'b0;
         end else begin
            out_vld_in = 1'b0;
         end
      end
      if (accept) begin
         slot0_in = '{base_letter: lanes[0].base_letter, quality: lanes[0].quality,
                      last_of_item: ~lanes[1].keep};
         slot1_in = '{base_letter: lanes[1].base_letter, quality: lanes[1].quality,
                      last_of_item: 1'b1};
         vld0_in  = lanes[0].keep;
         vld1_in  = lanes[1].keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff    <= 1'b0;
         vld1_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         vld0_ff    <= vld0_in;
         vld1_ff    <= vld1_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      out_ff   <= out_in;
   end

   assign rsp_bus.valid        = out_vld_ff;
   assign rsp_bus.base_letter  = out_ff.base_letter;
   assign rsp_bus.quality      = out_ff.quality;
   assign rsp_bus.last_of_item = out_ff.last_of_item;

endmodule

### sv/bcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_checker
// Port-level checks of the basecall byte decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bcd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bcd_pkg::LETTER_W-1:0]  rsp_base_letter,
   input logic [bcd_pkg::QUAL_W-1:0]    rsp_quality,
   input logic                          rsp_last_of_item
);
   import bcd_pkg::*;

   // Nothing comes out in the cycle after reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_base_letter) && $stable(rsp_quality)
                                  && $stable(rsp_last_of_item))
      else $error("result changed while stalled");

   // A zero quality always reads as N, and N only comes from a zero quality.
   a_n_means_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_quality == '0) == (rsp_base_letter == LETTER_N)))
      else $error("N letter and zero quality disagree");

   // The second result of an item is already held, so it follows at once.
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_item |=> rsp_valid)
      else $error("gap inside an item's results");

endmodule

bind basecall_byte_decoder bcd_checker u_bcd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_base_letter  (rsp_bus.base_letter),
   .rsp_quality      (rsp_bus.quality),
   .rsp_last_of_item (rsp_bus.last_of_item)
);
